// ===== sv/nearest_centroid_search_defines.svh =====
// Assertion macros shared by the nearest centroid search RTL.
`ifndef NEAREST_CENTROID_SEARCH_DEFINES_SVH
`define NEAREST_CENTROID_SEARCH_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, masked while reset is asserted.
`define NCS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("nearest_centroid_search: assertion failed");
// Clocked check that also covers the reset cycles.
`define NCS_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("nearest_centroid_search: reset assertion failed");
`else
`define NCS_ASSERT(lbl, clk, rstn, prop)
`define NCS_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// ===== sv/ncs_pkg.sv =====
// Shared constants and types for the nearest centroid search block.
`timescale 1ns / 1ps

package ncs_pkg;

    // Parameter defaults
    localparam int DEF_MAX_CENTROIDS = 256;
    localparam int DEF_MAX_DIMS      = 128;
    localparam int DEF_VALUE_WIDTH   = 16;

    // Fixed field widths
    localparam int IN_CIDX_W  = 8;
    localparam int IN_EIDX_W  = 7;
    localparam int IN_VALUE_W = 16;
    localparam int IDX_W      = 8;
    localparam int DIST_W     = 39;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 9;
    localparam int CNT_CFG_W  = 9;
    localparam int DIM_CFG_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CENTROID_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS_USED      = 8'd1;

    localparam logic [CNT_CFG_W-1:0] CNT_RESET  = 9'd256;
    localparam logic [DIM_CFG_W-1:0] DIMS_RESET = 8'd128;

    // Input kind carried in tuser
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Position flags that travel with each element through the datapath
    typedef struct packed {
        logic valid;
        logic first_e;
        logic last_e;
        logic first_c;
        logic last_c;
    } ncs_tag_t;

    // Controller to datapath
    typedef struct packed {
        logic     wr_load;
        logic     wr_query;
        ncs_tag_t issue;
        logic     out_load;
    } ncs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic search_done;
    } ncs_status_t;

endpackage

// ===== sv/ncs_datapath.sv =====
// Centroid store, query buffer, distance pipeline and result registers.
`timescale 1ns / 1ps

module ncs_datapath import ncs_pkg::*; #(
    parameter int MAX_CENTROIDS = DEF_MAX_CENTROIDS,
    parameter int MAX_DIMS      = DEF_MAX_DIMS,
    parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH,
    parameter int CW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1,
    parameter int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ncs_cmd_t              cmd,
    input  logic [CW-1:0]         rd_cidx,
    input  logic [DW-1:0]         rd_eidx,
    input  logic [IN_CIDX_W-1:0]  in_cidx,
    input  logic [IN_EIDX_W-1:0]  in_eidx,
    input  logic [IN_VALUE_W-1:0] in_value,
    output ncs_status_t           status,
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int VW   = VALUE_WIDTH;
    localparam int SQ_W = 2 * VW;
    localparam int MW   = (SQ_W > DIST_W) ? SQ_W : DIST_W + 1;
    localparam int CDEPTH = 1 << (CW + DW);
    localparam int QDEPTH = 1 << DW;

    logic [VW-1:0] cmem [CDEPTH];
    logic [VW-1:0] qmem [QDEPTH];

    logic [VW-1:0] wr_val;
    logic          cidx_ok;
    logic          eidx_ok;

    generate
        if (VW <= IN_VALUE_W) begin : g_narrow
            assign wr_val = in_value[VW-1:0];
        end else begin : g_wide
            assign wr_val = {{(VW-IN_VALUE_W){1'b0}}, in_value};
        end
    endgenerate

    assign cidx_ok = (32'(in_cidx) < MAX_CENTROIDS);
    assign eidx_ok = (32'(in_eidx) < MAX_DIMS);

    // Stage 1: memory reads
    logic [VW-1:0] c_rd_reg;
    logic [VW-1:0] q_rd_reg;
    ncs_tag_t      t1_reg;
    logic [CW-1:0] c1_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_load && cidx_ok && eidx_ok) begin
            cmem[{CW'(in_cidx), DW'(in_eidx)}] <= wr_val;
        end
        c_rd_reg <= cmem[{rd_cidx, rd_eidx}];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_query && eidx_ok) begin
            qmem[DW'(in_eidx)] <= wr_val;
        end
        q_rd_reg <= qmem[rd_eidx];
    end

    // Stage 2: absolute difference
    logic [VW:0]   diff;
    logic [VW:0]   diff_neg;
    logic [VW-1:0] absd_reg;
    ncs_tag_t      t2_reg;
    logic [CW-1:0] c2_reg;

    assign diff     = {q_rd_reg[VW-1], q_rd_reg} - {c_rd_reg[VW-1], c_rd_reg};
    assign diff_neg = ~diff + {{VW{1'b0}}, 1'b1};

    // Stage 3: square
    logic [SQ_W-1:0] sq_reg;
    ncs_tag_t        t3_reg;
    logic [CW-1:0]   c3_reg;

    // Stage 4: saturating accumulate
    logic [MW-1:0]     sq_w;
    logic [DIST_W-1:0] term;
    logic [DIST_W:0]   acc_sum;
    logic [DIST_W-1:0] acc_reg;
    ncs_tag_t          t4_reg;
    logic [CW-1:0]     c4_reg;

    assign sq_w    = MW'(sq_reg);
    assign term    = (sq_w > MW'(DIST_MAX)) ? DIST_MAX : DIST_W'(sq_w);
    assign acc_sum = {1'b0, acc_reg} + {1'b0, term};

    // Stage 5: running minimum
    logic [DIST_W-1:0] best_reg;
    logic [CW-1:0]     best_idx_reg;
    logic              done_reg;
    logic [DIST_W-1:0] m_dist_reg;
    logic [IDX_W-1:0]  m_idx_reg;

    always_ff @(posedge aclk) begin
        c1_reg   <= rd_cidx;
        absd_reg <= diff[VW] ? diff_neg[VW-1:0] : diff[VW-1:0];
        c2_reg   <= c1_reg;
        sq_reg   <= SQ_W'(absd_reg) * SQ_W'(absd_reg);
        c3_reg   <= c2_reg;
        c4_reg   <= c3_reg;
        if (t3_reg.valid) begin
            if (t3_reg.first_e) begin
                acc_reg <= term;
            end else begin
                acc_reg <= acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];
            end
        end
        // strict less-than keeps the lowest index on ties
        if (t4_reg.valid && t4_reg.last_e && (t4_reg.first_c || acc_reg < best_reg)) begin
            best_reg     <= acc_reg;
            best_idx_reg <= c4_reg;
        end
        if (cmd.out_load) begin
            m_dist_reg <= best_reg;
            m_idx_reg  <= IDX_W'(best_idx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg   <= '0;
            t2_reg   <= '0;
            t3_reg   <= '0;
            t4_reg   <= '0;
            done_reg <= 1'b0;
        end else begin
            t1_reg   <= cmd.issue;
            t2_reg   <= t1_reg;
            t3_reg   <= t2_reg;
            t4_reg   <= t3_reg;
            done_reg <= t4_reg.valid && t4_reg.last_e && t4_reg.last_c;
        end
    end

    assign status.search_done = done_reg;
    assign m_tdata = {{(M_TDATA_W-DIST_W-IDX_W){1'b0}}, m_dist_reg, m_idx_reg};

endmodule

// ===== sv/ncs_ctrl.sv =====
// Search sequencer, configuration registers and output handshake.
`timescale 1ns / 1ps

module ncs_ctrl import ncs_pkg::*; #(
    parameter int MAX_CENTROIDS = DEF_MAX_CENTROIDS,
    parameter int MAX_DIMS      = DEF_MAX_DIMS,
    parameter int CW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1,
    parameter int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_mode,
    input  logic                  s_last,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  ncs_status_t           status,
    output ncs_cmd_t              cmd,
    output logic [CW-1:0]         rd_cidx,
    output logic [DW-1:0]         rd_eidx
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_HOLD
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_CFG_W-1:0]   count_reg, count_next;
    logic [DIM_CFG_W-1:0]   dims_reg, dims_next;
    logic [CW-1:0]          c_reg, c_next;
    logic [DW-1:0]          e_reg, e_next;
    logic [CW-1:0]          cnt_m1_reg, cnt_m1_next;
    logic [DW-1:0]          dims_m1_reg, dims_m1_next;
    logic                   out_valid_reg, out_valid_next;

    logic accept;
    logic cfg_wr;
    logic out_free;
    logic [CW-1:0] cnt_m1_clamp;
    logic [DW-1:0] dims_m1_clamp;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign rd_cidx   = c_reg;
    assign rd_eidx   = e_reg;

    // zero acts as one, anything past the store size is clamped
    always_comb begin
        if (count_reg == '0) begin
            cnt_m1_clamp = '0;
        end else if (32'(count_reg) >= MAX_CENTROIDS) begin
            cnt_m1_clamp = CW'(MAX_CENTROIDS - 1);
        end else begin
            cnt_m1_clamp = CW'(count_reg - CNT_CFG_W'(1));
        end
        if (dims_reg == '0) begin
            dims_m1_clamp = '0;
        end else if (32'(dims_reg) >= MAX_DIMS) begin
            dims_m1_clamp = DW'(MAX_DIMS - 1);
        end else begin
            dims_m1_clamp = DW'(dims_reg - DIM_CFG_W'(1));
        end
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        dims_next      = dims_reg;
        c_next         = c_reg;
        e_next         = e_reg;
        cnt_m1_next    = cnt_m1_reg;
        dims_m1_next   = dims_m1_reg;
        out_valid_next = out_valid_reg && !m_tready;

        cmd.wr_load       = accept && (s_mode == MODE_LOAD);
        cmd.wr_query      = accept && (s_mode == MODE_QUERY);
        cmd.issue.valid   = (state_reg == ST_RUN);
        cmd.issue.first_e = (e_reg == '0);
        cmd.issue.last_e  = (e_reg == dims_m1_reg);
        cmd.issue.first_c = (c_reg == '0);
        cmd.issue.last_c  = (c_reg == cnt_m1_reg);
        cmd.out_load      = (state_reg == ST_HOLD) && out_free;

        if (cfg_wr) begin
            case (cfg_index)
                REG_CENTROID_COUNT: count_next = cfg_data;
                REG_DIMS_USED:      dims_next  = cfg_data[DIM_CFG_W-1:0];
                default:            ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_mode == MODE_QUERY) && s_last) begin
                    c_next       = '0;
                    e_next       = '0;
                    cnt_m1_next  = cnt_m1_clamp;
                    dims_m1_next = dims_m1_clamp;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN: begin
                if (e_reg == dims_m1_reg) begin
                    e_next = '0;
                    if (c_reg == cnt_m1_reg) begin
                        state_next = ST_DRAIN;
                    end else begin
                        c_next = c_reg + CW'(1);
                    end
                end else begin
                    e_next = e_reg + DW'(1);
                end
            end
            ST_DRAIN: begin
                if (status.search_done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= CNT_RESET;
            dims_reg      <= DIMS_RESET;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            dims_reg      <= dims_next;
        end
        c_reg       <= c_next;
        e_reg       <= e_next;
        cnt_m1_reg  <= cnt_m1_next;
        dims_m1_reg <= dims_m1_next;
    end

endmodule

// ===== sv/nearest_centroid_search.sv =====
// Top level of the brute-force nearest centroid search.
//
//   channel   dir  handshake              word
//   s_*       in   s_tvalid / s_tready    tdata, tuser = mode, tlast = last
//   m_*       out  m_tvalid / m_tready    tdata = nearest_index, best_distance_sq
//   cfg_*     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Load and non-last query words are accepted while s_tready is high.
// A query word with tlast starts a search of count * dims elements through one
// multiplier (one element of one centroid per cycle, single-port store read),
// and s_tready stays low until the result is loaded into the output register.
// The result sits in an output register; a new search may run while it waits
// and only stalls at the end if m_tready has not taken the previous word.
// aresetn is synchronous; store contents are not cleared and need no sweep.
`timescale 1ns / 1ps
`include "nearest_centroid_search_defines.svh"

module nearest_centroid_search import ncs_pkg::*; #(
    parameter int MAX_CENTROIDS = DEF_MAX_CENTROIDS,
    parameter int MAX_DIMS      = DEF_MAX_DIMS,
    parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input word stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [7:0] centroid_index, [14:8] element_index, [30:15] value, [31] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] mode
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] nearest_index, [46:8] best_distance_sq, [47] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
    localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    localparam int CIDX_LO  = 0;
    localparam int EIDX_LO  = CIDX_LO + IN_CIDX_W;
    localparam int VALUE_LO = EIDX_LO + IN_EIDX_W;

    ncs_cmd_t      cmd;
    ncs_status_t   status;
    logic [CW-1:0] rd_cidx;
    logic [DW-1:0] rd_eidx;

    // sequencer: owns the input/output handshakes and the register file
    ncs_ctrl #(
        .MAX_CENTROIDS (MAX_CENTROIDS),
        .MAX_DIMS      (MAX_DIMS),
        .CW            (CW),
        .DW            (DW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_mode    (s_tuser),
        .s_last    (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd),
        .rd_cidx   (rd_cidx),
        .rd_eidx   (rd_eidx)
    );

    // datapath: memories, diff/square/accumulate/min pipeline
    ncs_datapath #(
        .MAX_CENTROIDS (MAX_CENTROIDS),
        .MAX_DIMS      (MAX_DIMS),
        .VALUE_WIDTH   (VALUE_WIDTH),
        .CW            (CW),
        .DW            (DW)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .rd_cidx  (rd_cidx),
        .rd_eidx  (rd_eidx),
        .in_cidx  (s_tdata[CIDX_LO +: IN_CIDX_W]),
        .in_eidx  (s_tdata[EIDX_LO +: IN_EIDX_W]),
        .in_value (s_tdata[VALUE_LO +: IN_VALUE_W]),
        .status   (status),
        .m_tdata  (m_tdata)
    );

    // no input is taken while the search pipeline is being fed
    `NCS_ASSERT(a_issue_blocks_input, aclk, aresetn, cmd.issue.valid |-> !s_tready)
    // a finished result never overwrites a word not yet taken
    `NCS_ASSERT(a_load_only_when_free, aclk, aresetn, cmd.out_load |-> (!m_tvalid || m_tready))
    // completion only arrives once issuing has stopped
    `NCS_ASSERT(a_done_after_issue, aclk, aresetn, status.search_done |-> (!s_tready && !cmd.issue.valid))
    // reset leaves the block idle with no result pending
    `NCS_ASSERT_NR(a_reset_idle, aclk, !aresetn |=> (!m_tvalid && s_tready))

endmodule
